// ===== hw/rtl/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types and codes of the thermostat hysteresis controller.
// ----------------------------------------------------------------------------
package thc_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes, byte address is 4 * index
	localparam logic [1:0] REG_SET_POINT    = 2'd0;
	localparam logic [1:0] REG_BAND         = 2'd1;
	localparam logic [1:0] REG_BLINK_PERIOD = 2'd2;

	// Tick modes
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_SENSE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HEAT = 3'b010,
		ST_COOL = 3'b100
	} ctrl_state_t;

	typedef struct packed {
		logic signed [7:0] set_point;
		logic [6:0]        band;
		logic [7:0]        blink_period;
	} cfg_t;

	typedef struct packed {
		logic       heater;
		logic       cooler;
		logic       led;
		logic [7:0] average;
		logic       average_valid;
	} result_t;

endpackage

// ===== hw/rtl/thc_if.sv =====
// ----------------------------------------------------------------------------
// thc_if
// Valid/ready channels: tick requests in, status results out.
// ----------------------------------------------------------------------------
interface thc_tick_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink (input valid, input mode, input sample, output ready);
endinterface

interface thc_status_if;
	logic       valid;
	logic       ready;
	logic       heater;
	logic       cooler;
	logic       led;
	logic [7:0] average;
	logic       average_valid;

	modport source (output valid, output heater, output cooler, output led,
		output average, output average_valid, input ready);
	modport sink (input valid, input heater, input cooler, input led,
		input average, input average_valid, output ready);
endinterface

// ===== hw/rtl/thermostat_hysteresis_controller.sv =====
// ----------------------------------------------------------------------------
// thermostat_hysteresis_controller
// Averaging bang-bang thermostat with hysteresis and APB register port.
// ----------------------------------------------------------------------------
// An accepted request waits in the tick register; its result then goes to
// the result register. Throughput: one request per cycle unless stalled;
// block state and result register update together; both hold under stall.
// Reset: arst_n clears the block state, the pipeline valids and the
// registers to set_point 0, band 5, blink_period 10.
module thermostat_hysteresis_controller
	import thc_pkg::*;
#(
	parameter int SAMPLES = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	thc_tick_if.sink          tick,
	thc_status_if.source      status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] sample_s1;
	logic       out_valid_q;
	result_t    res, res_q;
	logic       advance, take, wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr      = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_point    <= 8'sd0;
			cfg_q.band         <= 7'd5;
			cfg_q.blink_period <= 8'd10;
		end else if (wr) begin
			case (reg_idx)
				REG_SET_POINT:    cfg_q.set_point    <= pwdata[7:0];
				REG_BAND:         cfg_q.band         <= pwdata[6:0];
				REG_BLINK_PERIOD: cfg_q.blink_period <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SET_POINT:    prdata = DATA_W'(unsigned'(cfg_q.set_point));
			REG_BAND:         prdata = DATA_W'(cfg_q.band);
			REG_BLINK_PERIOD: prdata = DATA_W'(cfg_q.blink_period);
			default:          prdata = '0;
		endcase
	end

	// Advance the held request whenever the result register can take it
	assign advance    = valid_s1 & (~out_valid_q | status.ready);
	assign tick.ready = ~valid_s1 | advance;
	assign take       = tick.valid & tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (status.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1   <= tick.mode;
			sample_s1 <= tick.sample;
		end
		if (advance)
			res_q <= res;
	end

	thc_core #(
		.SAMPLES(SAMPLES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.mode   (mode_s1),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign status.valid         = out_valid_q;
	assign status.heater        = res_q.heater;
	assign status.cooler        = res_q.cooler;
	assign status.led           = res_q.led;
	assign status.average       = res_q.average;
	assign status.average_valid = res_q.average_valid;

endmodule

// ===== hw/rtl/thc_core.sv =====
// ----------------------------------------------------------------------------
// thc_core
// Block averaging and heat/cool state machine, one tick per step strobe.
// ----------------------------------------------------------------------------
module thc_core
	import thc_pkg::*;
#(
	parameter int SAMPLES = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] mode,
	input  logic [7:0] sample,
	input  cfg_t       cfg,
	output result_t    res
);

	localparam int SUM_W = $clog2(255 * SAMPLES + 1);
	localparam int CNT_W = $clog2(SAMPLES + 1);
	// Reciprocal is exact for every SUM_W-bit sum at this shift
	localparam int RSH = SUM_W + $clog2(SAMPLES);
	localparam logic [RSH:0] RECIP = (RSH + 1)'(((2 ** RSH) + SAMPLES - 1) / SAMPLES);
	localparam int PROD_W = SUM_W + RSH + 1;

	logic [SUM_W-1:0]  sum_q, sum_n, sum_add;
	logic [CNT_W-1:0]  cnt_q, cnt_n, cnt_inc;
	logic [7:0]        avg_q, avg_n, quot, blink_q, blink_n, blink_inc;
	logic              rdy_q, rdy_n;
	logic              heat_q, heat_n, cool_q, cool_n, led_q, led_n;
	ctrl_state_t       st_q, st_n;
	logic [PROD_W-1:0] prod;
	logic signed [9:0] diff, band_s;
	logic              go_heat, go_cool;

	assign sum_add   = sum_q + SUM_W'(sample);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign prod      = PROD_W'(sum_add) * PROD_W'(RECIP);
	assign quot      = prod[RSH +: 8];
	assign blink_inc = blink_q + 8'd1;

	always_comb begin
		sum_n   = sum_q;
		cnt_n   = cnt_q;
		avg_n   = avg_q;
		rdy_n   = rdy_q;
		st_n    = st_q;
		blink_n = blink_q;
		heat_n  = heat_q;
		cool_n  = cool_q;
		led_n   = led_q;
		case (mode)
			MODE_SET: begin
				heat_n = 1'b0;
				cool_n = 1'b0;
			end
			MODE_SENSE: begin
				if (cnt_inc >= CNT_W'(SAMPLES)) begin
					avg_n = quot;
					rdy_n = 1'b1;
					sum_n = '0;
					cnt_n = '0;
				end else begin
					sum_n = sum_add;
					cnt_n = cnt_inc;
				end
			end
			default: ;
		endcase
		// Compare against the freshly latched average
		diff    = $signed({2'b00, avg_n}) - 10'(cfg.set_point);
		band_s  = $signed({3'b000, cfg.band});
		go_heat = diff < -band_s;
		go_cool = diff >= band_s;
		if (mode == MODE_SENSE && rdy_n) begin
			case (st_q)
				ST_HEAT: begin
					heat_n = 1'b1;
					cool_n = 1'b0;
					if (blink_inc == cfg.blink_period) begin
						led_n   = ~led_q;
						blink_n = '0;
					end else begin
						blink_n = blink_inc;
					end
					if (go_cool)
						st_n = ST_COOL;
				end
				ST_COOL: begin
					heat_n = 1'b0;
					cool_n = 1'b1;
					led_n  = 1'b1;
					if (go_heat)
						st_n = ST_HEAT;
				end
				default: begin
					heat_n = 1'b0;
					cool_n = 1'b0;
					led_n  = 1'b0;
					st_n   = go_heat ? ST_HEAT : ST_COOL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			avg_q   <= '0;
			rdy_q   <= 1'b0;
			st_q    <= ST_IDLE;
			blink_q <= '0;
			heat_q  <= 1'b0;
			cool_q  <= 1'b0;
			led_q   <= 1'b0;
		end else if (step) begin
			sum_q   <= sum_n;
			cnt_q   <= cnt_n;
			avg_q   <= avg_n;
			rdy_q   <= rdy_n;
			st_q    <= st_n;
			blink_q <= blink_n;
			heat_q  <= heat_n;
			cool_q  <= cool_n;
			led_q   <= led_n;
		end
	end

	assign res.heater        = heat_n;
	assign res.cooler        = cool_n;
	assign res.led           = led_n;
	assign res.average       = avg_n;
	assign res.average_valid = rdy_n;

endmodule

// ===== dv/thermostat_hysteresis_controller_tb.sv =====
// ----------------------------------------------------------------------------
// thermostat_hysteresis_controller_tb
// Self-checking bench for the averaging thermostat. Tick requests go in on
// the valid/ready channel while a cycle-free predictor tracks block sums,
// averages and the idle/heat/cool controller; every status result is
// compared field by field against it or its typed opening row. Register
// settings change between phases over the APB port, each write is read back.
// ----------------------------------------------------------------------------
module thermostat_hysteresis_controller_tb;
	import thc_pkg::*;

	localparam int THERMO_SAMPLES = 10;
	localparam int STALL_LIMIT    = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int REPORT_MAX     = 10;

	// Tick modes that the block treats as no action
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] sample;
		bit         typed;
		result_t    want;
	} tick_row_t;

	typedef struct {
		int sp;
		int bnd;
		int period;
		int items;
		bit heat_bias;
	} phase_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	thc_tick_if   tick_ch ();
	thc_status_if status_ch ();

	thermostat_hysteresis_controller #(
		.SAMPLES (THERMO_SAMPLES)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.status  (status_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// Predictor state
	cfg_t        thermo_cfg;
	logic [11:0] acc_sum;
	logic [3:0]  acc_cnt;
	logic        avg_ok;
	logic [7:0]  avg_val;
	ctrl_state_t ctrl_st;
	logic [7:0]  blink_cnt;
	logic        heat_lvl;
	logic        cool_lvl;
	logic        led_lvl;

	result_t status_due[$];

	int  fault_count = 0;
	int  checked     = 0;
	int  heat_seen   = 0;
	int  cool_seen   = 0;
	int  ticks_sent  = 0;
	int  idle_run    = 0;
	bit  steady      = 1'b0;
	bit  hold_req    = 1'b0;
	int  hold_left   = 0;

	tick_row_t opening_ticks [25] = '{
		'{MODE_IDLE,  8'd0,   1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SPARE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SET,   8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0,   1'b0}},
		// first full block: average latched, controller leaves idle
		'{MODE_SENSE, 8'd255, 1'b1, {1'b0, 1'b0, 1'b0, 8'd255, 1'b1}},
		'{MODE_SENSE, 8'd0,   1'b1, {1'b0, 1'b1, 1'b1, 8'd255, 1'b1}},
		// set-temp drops both drives, lamp stays
		'{MODE_SET,   8'd0,   1'b1, {1'b0, 1'b0, 1'b1, 8'd255, 1'b1}},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0},
		'{MODE_SENSE, 8'd0,   1'b0, '0}
	};

	phase_t phases [8];

	function automatic int clamp_deg(int v);
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	function automatic result_t thermo_step(logic [1:0] m, logic [7:0] s);
		logic signed [9:0] diff;
		logic signed [9:0] lim;
		result_t           r;
		if (m == MODE_SET) begin
			heat_lvl = 1'b0;
			cool_lvl = 1'b0;
		end else if (m == MODE_SENSE) begin
			acc_sum = acc_sum + 12'(s);
			acc_cnt = acc_cnt + 4'd1;
			if (acc_cnt >= THERMO_SAMPLES) begin
				avg_val = 8'(acc_sum / THERMO_SAMPLES);
				avg_ok  = 1'b1;
				acc_sum = '0;
				acc_cnt = '0;
			end
			if (avg_ok) begin
				diff = $signed({2'b00, avg_val}) - thermo_cfg.set_point;
				lim  = $signed({3'b000, thermo_cfg.band});
				case (ctrl_st)
					ST_HEAT: begin
						cool_lvl  = 1'b0;
						heat_lvl  = 1'b1;
						blink_cnt = blink_cnt + 8'd1;
						if (blink_cnt == thermo_cfg.blink_period) begin
							led_lvl   = ~led_lvl;
							blink_cnt = '0;
						end
						if (diff >= lim)
							ctrl_st = ST_COOL;
					end
					ST_COOL: begin
						heat_lvl = 1'b0;
						cool_lvl = 1'b1;
						led_lvl  = 1'b1;
						if (diff < -lim)
							ctrl_st = ST_HEAT;
					end
					default: begin
						heat_lvl = 1'b0;
						cool_lvl = 1'b0;
						led_lvl  = 1'b0;
						ctrl_st  = (diff < -lim) ? ST_HEAT : ST_COOL;
					end
				endcase
			end
		end
		r.heater        = heat_lvl;
		r.cooler        = cool_lvl;
		r.led           = led_lvl;
		r.average       = avg_val;
		r.average_valid = avg_ok;
		return r;
	endfunction

	task automatic flag_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("MISMATCH: %s", msg);
	endtask

	// Offer one tick request, with random gaps ahead of it unless steady is set
	task automatic offer_tick(input logic [1:0] m, input logic [7:0] s, input bit typed,
			input result_t want);
		result_t p;
		while (!steady && $urandom_range(99) < 36) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid  <= 1'b1;
		tick_ch.mode   <= m;
		tick_ch.sample <= s;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		p = thermo_step(m, s);
		status_due.push_back(typed ? want : p);
		ticks_sent++;
	endtask

	// Hold the request side until every expected result is back
	task automatic drain_status();
		tick_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (status_due.size() != 0);
	endtask

	task automatic apb_access(input bit wr, input logic [1:0] idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] mask;
		apb_access(1'b1, idx, value, rd);
		case (idx)
			REG_SET_POINT: begin
				thermo_cfg.set_point = value[7:0];
				mask = 32'h0000_00FF;
			end
			REG_BAND: begin
				thermo_cfg.band = value[6:0];
				mask = 32'h0000_007F;
			end
			REG_BLINK_PERIOD: begin
				thermo_cfg.blink_period = value[7:0];
				mask = 32'h0000_00FF;
			end
			default: mask = '0;
		endcase
		apb_access(1'b0, idx, '0, rd);
		if ((rd & mask) != (value & mask))
			flag_fault($sformatf("register %0d read back %0h, wrote %0h", idx, rd & mask,
				value & mask));
	endtask

	task automatic apply_settings(input int sp, input int bnd, input int period);
		write_reg(REG_SET_POINT, DATA_W'(sp));
		write_reg(REG_BAND, DATA_W'(bnd));
		write_reg(REG_BLINK_PERIOD, DATA_W'(period));
	endtask

	// Receiver: random stalls unless steady is set, plus one long hold-off on request
	initial begin
		status_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				status_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				status_ch.ready <= steady || ($urandom_range(99) >= 36);
			end
		end
	end

	always @(posedge clk) begin : status_check
		result_t got;
		result_t want;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			got.heater        = status_ch.heater;
			got.cooler        = status_ch.cooler;
			got.led           = status_ch.led;
			got.average       = status_ch.average;
			got.average_valid = status_ch.average_valid;
			if (status_due.size() == 0) begin
				flag_fault($sformatf("unexpected result h%0b c%0b led%0b avg%0d v%0b",
					got.heater, got.cooler, got.led, got.average, got.average_valid));
			end else begin
				want = status_due.pop_front();
				checked++;
				if (got.heater)
					heat_seen++;
				if (got.cooler)
					cool_seen++;
				if (got.heater !== want.heater || got.cooler !== want.cooler ||
						got.led !== want.led || got.average !== want.average ||
						got.average_valid !== want.average_valid)
					flag_fault($sformatf({"result %0d: expected h%0b c%0b led%0b avg%0d v%0b,",
						" got h%0b c%0b led%0b avg%0d v%0b"}, checked,
						want.heater, want.cooler, want.led, want.average, want.average_valid,
						got.heater, got.cooler, got.led, got.average, got.average_valid));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int         sent;
		int         blk_left;
		int         center;
		int         lo;
		int         hi;
		int         r;
		logic [7:0] s;
		phase_t     ph;

		arst_n         = 1'b0;
		tick_ch.valid  = 1'b0;
		tick_ch.mode   = MODE_IDLE;
		tick_ch.sample = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;

		thermo_cfg.set_point    = 8'sd0;
		thermo_cfg.band         = 7'd5;
		thermo_cfg.blink_period = 8'd10;
		acc_sum   = '0;
		acc_cnt   = '0;
		avg_ok    = 1'b0;
		avg_val   = '0;
		ctrl_st   = ST_IDLE;
		blink_cnt = '0;
		heat_lvl  = 1'b0;
		cool_lvl  = 1'b0;
		led_lvl   = 1'b0;

		phases[0] = '{-128, 127, 255, 200, 1'b0};
		phases[1] = '{127, 0, 1, 200, 1'b0};
		phases[2] = '{25, 3, 4, 200, 1'b0};
		phases[3] = '{40, 10, 0, 300, 1'b1};
		phases[4] = '{int'($urandom_range(255)) - 128, int'($urandom_range(127)),
			int'($urandom_range(255)), 200, 1'b0};
		phases[5] = '{0, 5, 10, 200, 1'b0};
		phases[6] = '{60, 2, 200, 300, 1'b1};
		// lower the period below the running count: the lamp waits for the wrap
		phases[7] = '{60, 2, 3, 300, 1'b1};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(127, 0, 1);
		foreach (opening_ticks[i])
			offer_tick(opening_ticks[i].mode, opening_ticks[i].sample, opening_ticks[i].typed,
				opening_ticks[i].want);

		foreach (phases[p]) begin
			ph = phases[p];
			drain_status();
			repeat (4) @(posedge clk);
			apply_settings(ph.sp, ph.bnd, ph.period);
			steady   = (p == 5);
			sent     = 0;
			blk_left = 0;
			while (sent < ph.items) begin
				r = $urandom_range(99);
				if (r < 5) begin
					offer_tick(r[0] ? MODE_IDLE : MODE_SPARE, 8'($urandom_range(255)), 1'b0, '0);
				end else begin
					if (r < 11) begin
						offer_tick(MODE_SET, 8'($urandom_range(255)), 1'b0, '0);
					end else begin
						if (blk_left == 0) begin
							if (ph.heat_bias) begin
								hi = ph.sp - ph.bnd - 4;
								lo = hi - 20;
							end else begin
								lo = ph.sp - ph.bnd - 15;
								hi = ph.sp + ph.bnd + 15;
							end
							lo = clamp_deg(lo);
							hi = clamp_deg(hi);
							if (lo > hi)
								lo = hi;
							center   = lo + int'($urandom_range(hi - lo, 0));
							blk_left = THERMO_SAMPLES;
						end
						if (!ph.heat_bias && $urandom_range(11) == 0)
							s = 8'($urandom_range(255));
						else
							s = 8'(clamp_deg(center + int'($urandom_range(6)) - 3));
						offer_tick(MODE_SENSE, s, 1'b0, '0);
						blk_left--;
					end
					sent++;
					if (p == 2 && sent == 100)
						hold_req = 1'b1;
					if (p == 4 && sent == 100)
						drain_status();
				end
			end
		end

		drain_status();
		steady = 1'b1;
		repeat (8) @(posedge clk);
		$display("Run covered %0d tick requests over %0d register settings and all four modes.",
			ticks_sent, 9);
		$display("Checked %0d results: heater on in %0d, cooler on in %0d.",
			checked, heat_seen, cool_seen);
		if (fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
